// ===== rtl/assert_macros.svh =====
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// ante true at an edge implies cons at the same edge
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// ante true at an edge implies cons at the next edge
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`else

`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)

`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ===== rtl/prcc_pkg.sv =====
package prcc_pkg;

	// input form codes; other codes are invalid
	typedef enum logic [1:0] {
		FORM_RECT  = 2'd0,
		FORM_POLAR = 2'd1
	} form_t;

	// sideband that rides along with each beat
	typedef struct packed {
		logic zero;
		logic err;
		logic mode;
	} side_t;

	// 1/K of the cordic in q0.24
	localparam logic [23:0] INV_GAIN = 24'd10188013;

	// fraction bits added below the coordinates inside the cordic
	localparam int GUARD_BITS = 8;

	// internal angle widths, 2^31 = 180 degrees
	localparam int RZ_WIDTH = 33;
	localparam int VZ_WIDTH = 34;

	// atan(2^-i) as binary angle, 2^32 = full turn
	localparam logic [31:0] ATAN_TAB [32] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
		32'd2670163, 32'd1335086, 32'd667544, 32'd333772,
		32'd166886, 32'd83443, 32'd41721, 32'd20860,
		32'd10430, 32'd5215, 32'd2607, 32'd1303,
		32'd651, 32'd325, 32'd162, 32'd81,
		32'd40, 32'd20, 32'd10, 32'd5,
		32'd2, 32'd1, 32'd0, 32'd0
	};

endpackage

// ===== rtl/polar_rect_coordinate_converter_top.sv =====
// polar / rectangular coordinate converter, fully pipelined cordic
//
// input channel s_*: s_tdata carries first_value and second_value, s_tuser the
// form code (rectangular, polar, anything else is flagged as an error). a
// rectangular beat passes x and y through; a polar beat is rotated into x and y
// by a rotation-mode cordic. every beat then gets length and direction of the
// resulting (x, y) from a vectoring-mode cordic.
//
// output channel m_*: m_tdata carries x, y, magnitude and angle, m_tuser the
// mode and the error flag. exactly one output beat per input beat, in order.
//
// the pipeline stages are: gain multiply, prescale, one register per rotation
// step, round, vector prep, one register per vectoring step, two stages of 1/K
// multiply. a new beat is taken every cycle while the output is not stalled.
// the last pipeline stage is the output register; when it holds a beat
// the receiver has not taken, the whole pipeline holds and s_tready drops, and
// it moves again in the cycle that beat is taken.
// reset clears the valid bits of every stage, nothing else needs clearing.
`include "assert_macros.svh"

module polar_rect_coordinate_converter_top #(
	parameter int COORD_WIDTH = 16,
	parameter int CORDIC_STAGES = 16
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        s_tvalid,
	output logic                                        s_tready,
	// first_value, second_value, zero pad
	input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]          s_tdata,
	// input_form
	input  logic [1:0]                                  s_tuser,
	output logic                                        m_tvalid,
	input  logic                                        m_tready,
	// out_x, out_y, out_magnitude, out_angle, zero pad
	output logic [((4*COORD_WIDTH+7)/8)*8-1:0]          m_tdata,
	// out_mode, form_error
	output logic [1:0]                                  m_tuser
);

	localparam int W   = COORD_WIDTH;
	localparam int N   = CORDIC_STAGES;
	localparam int XR  = W + 10;              // rotation datapath
	localparam int XV  = W + 11;              // vectoring datapath
	localparam int ZR  = prcc_pkg::RZ_WIDTH;
	localparam int ZV  = prcc_pkg::VZ_WIDTH;
	localparam int PW  = W + 25;              // magnitude times 1/K
	localparam int CW  = 2 * W;
	localparam int ZS  = 32 - W;
	localparam int GB  = prcc_pkg::GUARD_BITS;
	localparam int OTW = ((4*COORD_WIDTH+7)/8)*8;

	localparam logic signed [ZR-1:0] QTR_R   = ZR'(64'd1073741824);
	localparam logic signed [ZR-1:0] HALF_R  = ZR'(64'd2147483648);
	localparam logic signed [ZV-1:0] HALF_V  = ZV'(64'd2147483648);
	localparam logic signed [PW-1:0] GAIN_P  = PW'(prcc_pkg::INV_GAIN);
	localparam logic signed [PW-1:0] GAIN_RND = PW'(32768);
	localparam logic signed [XR-1:0] CRD_RND = XR'(1 << (GB - 1));
	localparam logic signed [XR-1:0] SAT_HI  = XR'((64'sd1 <<< (W - 1)) - 64'sd1);
	localparam logic signed [XR-1:0] SAT_LO  = ~SAT_HI;

	// drop guard bits with round half up, then clamp to the coordinate range
	function automatic logic [W-1:0] round_sat(input logic signed [XR-1:0] v);
		logic signed [XR-1:0] r;
		r = (v + CRD_RND) >>> GB;
		if (r > SAT_HI) begin
			return SAT_HI[W-1:0];
		end else if (r < SAT_LO) begin
			return SAT_LO[W-1:0];
		end
		return r[W-1:0];
	endfunction

	logic en;

	// input decode
	logic signed [W-1:0]  v1;
	logic signed [W-1:0]  v2;
	logic signed [ZR-1:0] za;
	logic signed [ZR-1:0] zf;
	logic                 flip;
	prcc_pkg::side_t      side_d;
	logic [CW-1:0]        pass_d;

	// s1: gain multiply and quadrant fold
	logic                 valid_s1;
	logic signed [PW-1:0] prod_s1;
	logic signed [ZR-1:0] z_s1;
	logic                 flip_s1;
	prcc_pkg::side_t      side_s1;
	logic [CW-1:0]        pass_s1;

	// s2: scaled start vector for the rotation
	logic signed [PW-1:0] prod_rnd;
	logic signed [PW-1:0] prod_sh;
	logic signed [XR-1:0] x0;
	logic                 valid_s2;
	logic signed [XR-1:0] x_s2;
	logic signed [ZR-1:0] z_s2;
	prcc_pkg::side_t      side_s2;
	logic [CW-1:0]        pass_s2;

	// rotation chain
	logic                 rot_valid [0:N];
	logic signed [XR-1:0] rot_x [0:N];
	logic signed [XR-1:0] rot_y [0:N];
	logic signed [ZR-1:0] rot_z [0:N];
	prcc_pkg::side_t      rot_side [0:N];
	logic [CW-1:0]        rot_carry [0:N];

	// s3: final x and y
	logic [W-1:0]         x_d;
	logic [W-1:0]         y_d;
	logic                 valid_s3;
	logic signed [W-1:0]  x_s3;
	logic signed [W-1:0]  y_s3;
	prcc_pkg::side_t      side_s3;

	// s4: vectoring start, right half plane
	logic signed [XV-1:0] xe;
	logic signed [XV-1:0] ye;
	logic                 neg_x;
	prcc_pkg::side_t      side_v;
	logic                 valid_s4;
	logic signed [XV-1:0] x_s4;
	logic signed [XV-1:0] y_s4;
	logic signed [ZV-1:0] z_s4;
	prcc_pkg::side_t      side_s4;
	logic [CW-1:0]        carry_s4;

	// vectoring chain
	logic                 vec_valid [0:N];
	logic signed [XV-1:0] vec_x [0:N];
	logic signed [XV-1:0] vec_y [0:N];
	logic signed [ZV-1:0] vec_z [0:N];
	prcc_pkg::side_t      vec_side [0:N];
	logic [CW-1:0]        vec_carry [0:N];

	// output stage
	logic                 out_valid;
	logic [W-1:0]         out_x;
	logic [W-1:0]         out_y;
	logic [W-1:0]         out_mag;
	logic [W-1:0]         out_ang;
	prcc_pkg::side_t      out_side;

	// one enable for the whole pipe: it moves unless the output beat is stuck
	assign en       = ~out_valid | m_tready;
	assign s_tready = en;

	assign v1 = s_tdata[W-1:0];
	assign v2 = s_tdata[2*W-1:W];

	// fold the angle into the right half, the magnitude flips sign instead
	always_comb begin
		za   = ZR'(v2) <<< ZS;
		zf   = za;
		flip = 1'b0;
		if (za > QTR_R) begin
			zf   = za - HALF_R;
			flip = 1'b1;
		end else if (za < -QTR_R) begin
			zf   = za + HALF_R;
			flip = 1'b1;
		end
	end

	always_comb begin
		side_d = '0;
		pass_d = '0;
		case (s_tuser)
			prcc_pkg::FORM_RECT: begin
				pass_d = {v2, v1};
			end
			prcc_pkg::FORM_POLAR: begin
				side_d.mode = 1'b1;
			end
			default: begin
				// invalid form: zero vector, rectangular mode
				side_d.err = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= s_tvalid;
			valid_s2 <= valid_s1;
			valid_s3 <= rot_valid[N];
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= PW'(v1) * GAIN_P;
			z_s1    <= zf;
			flip_s1 <= flip;
			side_s1 <= side_d;
			pass_s1 <= pass_d;
		end
	end

	// magnitude * 1/K, back to q.8 plus guard bits
	assign prod_rnd = prod_s1 + GAIN_RND;
	assign prod_sh  = prod_rnd >>> 16;
	assign x0       = flip_s1 ? -XR'(prod_sh) : XR'(prod_sh);

	always_ff @(posedge clk) begin
		if (en) begin
			x_s2    <= x0;
			z_s2    <= z_s1;
			side_s2 <= side_s1;
			pass_s2 <= pass_s1;
		end
	end

	assign rot_valid[0] = valid_s2;
	assign rot_x[0]     = x_s2;
	assign rot_y[0]     = '0;
	assign rot_z[0]     = z_s2;
	assign rot_side[0]  = side_s2;
	assign rot_carry[0] = pass_s2;

	for (genvar g = 0; g < N; g++) begin : g_rot
		prcc_cordic_stage #(
			.XW(XR),
			.ZW(ZR),
			.CW(CW),
			.IDX(g),
			.VECT(1'b0)
		) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_valid (rot_valid[g]),
			.in_x     (rot_x[g]),
			.in_y     (rot_y[g]),
			.in_z     (rot_z[g]),
			.in_side  (rot_side[g]),
			.in_carry (rot_carry[g]),
			.out_valid(rot_valid[g+1]),
			.out_x    (rot_x[g+1]),
			.out_y    (rot_y[g+1]),
			.out_z    (rot_z[g+1]),
			.out_side (rot_side[g+1]),
			.out_carry(rot_carry[g+1])
		);
	end

	// polar beats take the rotated vector, others their passed-through values
	assign x_d = rot_side[N].mode ? round_sat(rot_x[N]) : rot_carry[N][W-1:0];
	assign y_d = rot_side[N].mode ? round_sat(rot_y[N]) : rot_carry[N][2*W-1:W];

	always_ff @(posedge clk) begin
		if (en) begin
			x_s3    <= x_d;
			y_s3    <= y_d;
			side_s3 <= rot_side[N];
		end
	end

	// mirror the left half plane and start its angle at 180 degrees, else at 0
	assign neg_x = x_s3[W-1];
	assign xe    = XV'(x_s3);
	assign ye    = XV'(y_s3);

	always_comb begin
		side_v      = side_s3;
		side_v.zero = (x_s3 == '0) && (y_s3 == '0);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s4     <= (neg_x ? -xe : xe) <<< GB;
			y_s4     <= (neg_x ? -ye : ye) <<< GB;
			z_s4     <= neg_x ? HALF_V : '0;
			side_s4  <= side_v;
			carry_s4 <= {y_s3, x_s3};
		end
	end

	assign vec_valid[0] = valid_s4;
	assign vec_x[0]     = x_s4;
	assign vec_y[0]     = y_s4;
	assign vec_z[0]     = z_s4;
	assign vec_side[0]  = side_s4;
	assign vec_carry[0] = carry_s4;

	for (genvar g = 0; g < N; g++) begin : g_vec
		prcc_cordic_stage #(
			.XW(XV),
			.ZW(ZV),
			.CW(CW),
			.IDX(g),
			.VECT(1'b1)
		) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_valid (vec_valid[g]),
			.in_x     (vec_x[g]),
			.in_y     (vec_y[g]),
			.in_z     (vec_z[g]),
			.in_side  (vec_side[g]),
			.in_carry (vec_carry[g]),
			.out_valid(vec_valid[g+1]),
			.out_x    (vec_x[g+1]),
			.out_y    (vec_y[g+1]),
			.out_z    (vec_z[g+1]),
			.out_side (vec_side[g+1]),
			.out_carry(vec_carry[g+1])
		);
	end

	prcc_mag_scale #(
		.W(W)
	) u_mag (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vec_valid[N]),
		.in_x     (vec_x[N]),
		.in_z     (vec_z[N]),
		.in_side  (vec_side[N]),
		.in_carry (vec_carry[N]),
		.out_valid(out_valid),
		.out_x    (out_x),
		.out_y    (out_y),
		.out_mag  (out_mag),
		.out_ang  (out_ang),
		.out_side (out_side)
	);

	assign m_tvalid = out_valid;
	assign m_tdata  = OTW'({out_ang, out_mag, out_y, out_x});
	assign m_tuser  = {out_side.err, out_side.mode};

	`ASSERT_IMPLY(a_err_zero_xy, clk, arst_n, m_tvalid && m_tuser[1], (out_x == '0) && (out_y == '0) && !m_tuser[0], "invalid form beat must be a zero vector in rectangular mode")
	`ASSERT_IMPLY(a_err_zero_polar, clk, arst_n, m_tvalid && m_tuser[1], (out_mag == '0) && (out_ang == '0), "invalid form beat must have zero length and angle")
	`ASSERT_IMPLY(a_zero_vector, clk, arst_n, m_tvalid && (out_x == '0) && (out_y == '0), (out_mag == '0) && (out_ang == '0), "zero vector must report zero length and angle")
	`ASSERT_NEXT(a_stall_hold, clk, arst_n, !en && valid_s1, valid_s1 && $stable(prod_s1), "first stage must hold its beat while stalled")

endmodule

// ===== rtl/prcc_cordic_stage.sv =====
module prcc_cordic_stage #(
	parameter int XW = 26,
	parameter int ZW = 33,
	parameter int CW = 32,
	parameter int IDX = 0,
	parameter bit VECT = 1'b0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic signed [XW-1:0] in_x,
	input  logic signed [XW-1:0] in_y,
	input  logic signed [ZW-1:0] in_z,
	input  prcc_pkg::side_t      in_side,
	input  logic [CW-1:0]        in_carry,
	output logic                 out_valid,
	output logic signed [XW-1:0] out_x,
	output logic signed [XW-1:0] out_y,
	output logic signed [ZW-1:0] out_z,
	output prcc_pkg::side_t      out_side,
	output logic [CW-1:0]        out_carry
);

	logic signed [ZW-1:0] at;
	logic signed [XW-1:0] dx;
	logic signed [XW-1:0] dy;
	logic                 ccw;

	logic                 valid_s1;
	logic signed [XW-1:0] x_s1;
	logic signed [XW-1:0] y_s1;
	logic signed [ZW-1:0] z_s1;
	prcc_pkg::side_t      side_s1;
	logic [CW-1:0]        carry_s1;

	assign at = ZW'(prcc_pkg::ATAN_TAB[IDX]);
	assign dx = in_y >>> IDX;
	assign dy = in_x >>> IDX;
	// rotation steers on the residual angle, vectoring on the sign of y
	assign ccw = VECT ? in_y[XW-1] : ~in_z[ZW-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (ccw) begin
				x_s1 <= in_x - dx;
				y_s1 <= in_y + dy;
				z_s1 <= in_z - at;
			end else begin
				x_s1 <= in_x + dx;
				y_s1 <= in_y - dy;
				z_s1 <= in_z + at;
			end
			side_s1  <= in_side;
			carry_s1 <= in_carry;
		end
	end

	assign out_valid = valid_s1;
	assign out_x     = x_s1;
	assign out_y     = y_s1;
	assign out_z     = z_s1;
	assign out_side  = side_s1;
	assign out_carry = carry_s1;

endmodule

// ===== rtl/prcc_mag_scale.sv =====
module prcc_mag_scale #(
	parameter int W = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                in_valid,
	input  logic signed [W+10:0]                in_x,
	input  logic signed [prcc_pkg::VZ_WIDTH-1:0] in_z,
	input  prcc_pkg::side_t                     in_side,
	input  logic [2*W-1:0]                      in_carry,
	output logic                                out_valid,
	output logic [W-1:0]                        out_x,
	output logic [W-1:0]                        out_y,
	output logic [W-1:0]                        out_mag,
	output logic [W-1:0]                        out_ang,
	output prcc_pkg::side_t                     out_side
);

	localparam int XW  = W + 11;
	localparam int ZW  = prcc_pkg::VZ_WIDTH;
	localparam int HW  = XW - 17;
	localparam int PH  = HW + 24;
	localparam int PL  = 40;
	localparam int SW  = W + 35;
	localparam int HSH = (W < 32) ? 31 - W : 0;
	localparam logic signed [ZW-1:0] ANG_RND = (W < 32) ? (ZW'(1) << HSH) : '0;
	localparam logic [SW-1:0] MAG_RND = SW'(64'd2147483648);

	logic [XW-2:0]        xc;
	logic signed [ZW-1:0] za;
	logic [SW-1:0]        sum;
	logic [W+2:0]         mag_full;

	logic                 valid_s1;
	logic [PL-1:0]        pl_s1;
	logic [PH-1:0]        ph_s1;
	logic [W-1:0]         ang_s1;
	prcc_pkg::side_t      side_s1;
	logic [2*W-1:0]       carry_s1;

	logic                 valid_s2;
	logic [W-1:0]         x_s2;
	logic [W-1:0]         y_s2;
	logic [W-1:0]         mag_s2;
	logic [W-1:0]         ang_s2;
	prcc_pkg::side_t      side_s2;

	// negative length cannot come out of the loop, clamp anyway
	assign xc = in_x[XW-1] ? '0 : in_x[XW-2:0];
	assign za = in_z + ANG_RND;

	// two partial products against 1/K, joined next stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pl_s1    <= PL'(xc[15:0]) * PL'(prcc_pkg::INV_GAIN);
			ph_s1    <= PH'(xc[XW-2:16]) * PH'(prcc_pkg::INV_GAIN);
			ang_s1   <= za[32-W +: W];
			side_s1  <= in_side;
			carry_s1 <= in_carry;
		end
	end

	assign sum      = (SW'(ph_s1) << 16) + SW'(pl_s1) + MAG_RND;
	assign mag_full = sum[SW-1:32];

	always_ff @(posedge clk) begin
		if (en) begin
			x_s2    <= carry_s1[W-1:0];
			y_s2    <= carry_s1[2*W-1:W];
			side_s2 <= side_s1;
			if (side_s1.zero) begin
				mag_s2 <= '0;
				ang_s2 <= '0;
			end else begin
				mag_s2 <= (|mag_full[W+2:W]) ? '1 : mag_full[W-1:0];
				ang_s2 <= ang_s1;
			end
		end
	end

	assign out_valid = valid_s2;
	assign out_x     = x_s2;
	assign out_y     = y_s2;
	assign out_mag   = mag_s2;
	assign out_ang   = ang_s2;
	assign out_side  = side_s2;

endmodule
